// ----- src/ttst_pkg.sv -----
package ttst_pkg;

  localparam int SLOTS = 7;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int IDX_W = 3;
  localparam int DUR_W = 16;
  localparam int ACT_W = 8;
  localparam int TAG_W = 8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_TICK   = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_ADDED      = 3'd0,
    KIND_FULL       = 3'd1,
    KIND_CANCELLED  = 3'd2,
    KIND_QUIET_TICK = 3'd3,
    KIND_EXPIRED    = 3'd4
  } kind_e;

  typedef struct packed {
    logic [DUR_W-1:0] rem;
    logic [ACT_W-1:0] act;
    logic [TAG_W-1:0] tag;
  } slot_t;

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] slot_index;
    logic [ACT_W-1:0] fired_action;
    logic [TAG_W-1:0] fired_tag;
    logic             last;
  } result_t;

  // control from the sequencer to the ring of slot cells
  typedef struct packed {
    logic  shift;
    slot_t head_next;
  } ring_ctl_t;

endpackage

// ----- src/ttst_if.sv -----
interface ttst_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [ttst_pkg::DUR_W-1:0] duration;
  logic [ttst_pkg::ACT_W-1:0] action_code;
  logic [ttst_pkg::TAG_W-1:0] tag;
  logic                      hold;

  modport source (output valid, op, duration, action_code, tag, hold, input ready);
  modport sink (input valid, op, duration, action_code, tag, hold, output ready);
endinterface

interface ttst_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                kind;
  logic [ttst_pkg::IDX_W-1:0] slot_index;
  logic [ttst_pkg::ACT_W-1:0] fired_action;
  logic [ttst_pkg::TAG_W-1:0] fired_tag;
  logic                      last;

  modport source (output valid, kind, slot_index, fired_action, fired_tag, last,
                  input ready);
  modport sink (input valid, kind, slot_index, fired_action, fired_tag, last,
                output ready);
endinterface

// ----- src/tagged_timer_slot_table_top.sv -----
// Table of SLOTS countdown timers held in a ring of slot cells that rotates one
// place per cycle when not paused, past a single update point, so each slot is
// visited in order. Commands are add (first free slot), tick (decrement, report
// each expiry in slot order, last on the final result) and cancel by tag. After
// a command transfer the ring makes one full turn and the final result is then
// loaded. Command ready returns in the same cycle that the final result is
// offered. The ring pauses for every cycle that a second expiry finds the result
// port still holding an untaken result, and the final result waits for the
// result port to free. The unused op code is accepted and gives no result.
// Command ready is low while a command is in progress.
module tagged_timer_slot_table_top (
  input  logic        clk,
  input  logic        rst,
  ttst_cmd_if.sink    cmd,
  ttst_rsp_if.source  rsp
);

  ttst_pkg::ring_ctl_t ctl;
  ttst_pkg::slot_t     cell_q [ttst_pkg::SLOTS];

  for (genvar k = 0; k < ttst_pkg::SLOTS; k++) begin : g_cell
    ttst_pkg::slot_t d;
    if (k == ttst_pkg::SLOTS - 1) begin : g_tail
      assign d = ctl.head_next;
    end else begin : g_mid
      assign d = cell_q[k+1];
    end
    ttst_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctl.shift),
      .d     (d),
      .q     (cell_q[k])
    );
  end

  ttst_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .rsp  (rsp),
    .head (cell_q[0]),
    .ctl  (ctl)
  );

endmodule

// ----- src/ttst_cell.sv -----
module ttst_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  ttst_pkg::slot_t d,
  output ttst_pkg::slot_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ----- src/ttst_seq.sv -----
module ttst_seq (
  input  logic                clk,
  input  logic                rst,
  ttst_cmd_if.sink            cmd,
  ttst_rsp_if.source          rsp,
  input  ttst_pkg::slot_t     head,
  output ttst_pkg::ring_ctl_t ctl
);

  logic                         busy;
  logic [ttst_pkg::CNT_W-1:0]   cnt;
  ttst_pkg::op_e                op_r;
  logic [ttst_pkg::DUR_W-1:0]   dur_r;
  logic [ttst_pkg::ACT_W-1:0]   act_r;
  logic [ttst_pkg::TAG_W-1:0]   tag_r;
  logic                         hold_r;
  logic                         found;
  logic [ttst_pkg::IDX_W-1:0]   found_idx;
  logic                         pend_valid;
  ttst_pkg::result_t            pend;
  logic                         out_valid;
  ttst_pkg::result_t            out;

  logic                         scanning;
  logic                         expire;
  logic                         take;
  logic                         out_free;
  logic                         advance;
  logic                         finish;
  logic [ttst_pkg::IDX_W-1:0]   cur_idx;
  ttst_pkg::slot_t              head_next;
  ttst_pkg::result_t            final_res;

  assign scanning = busy && (cnt != ttst_pkg::CNT_W'(ttst_pkg::SLOTS));
  assign cur_idx  = ttst_pkg::IDX_W'(cnt);
  assign expire   = (op_r == ttst_pkg::OP_TICK) && !hold_r && (head.rem == 16'd1);
  assign take     = (op_r == ttst_pkg::OP_ADD) && !found && (head.rem == '0);
  assign out_free = !out_valid || rsp.ready;
  // an earlier expiry must leave for the output before a new one can wait
  assign advance  = scanning && !(expire && pend_valid && !out_free);
  assign finish   = busy && !scanning && out_free;

  always_comb begin
    head_next = head;
    case (op_r)
      ttst_pkg::OP_ADD: begin
        if (take) begin
          head_next.rem = dur_r;
          head_next.act = act_r;
          head_next.tag = tag_r;
        end
      end
      ttst_pkg::OP_TICK: begin
        if (!hold_r && head.rem != '0) begin
          head_next.rem = head.rem - 16'd1;
        end
      end
      ttst_pkg::OP_CANCEL: begin
        if (head.tag == tag_r) begin
          head_next.rem = '0;
        end
      end
      default: begin
        head_next = head;
      end
    endcase
  end

  always_comb begin
    final_res      = '0;
    final_res.last = 1'b1;
    case (op_r)
      ttst_pkg::OP_ADD: begin
        if (found) begin
          final_res.kind       = ttst_pkg::KIND_ADDED;
          final_res.slot_index = found_idx;
        end else begin
          final_res.kind = ttst_pkg::KIND_FULL;
        end
      end
      ttst_pkg::OP_TICK: begin
        if (pend_valid) begin
          final_res      = pend;
          final_res.last = 1'b1;
        end else begin
          final_res.kind = ttst_pkg::KIND_QUIET_TICK;
        end
      end
      default: begin
        final_res.kind = ttst_pkg::KIND_CANCELLED;
      end
    endcase
  end

  assign ctl.shift     = advance;
  assign ctl.head_next = head_next;

  assign cmd.ready        = !busy;
  assign rsp.valid        = out_valid;
  assign rsp.kind         = out.kind;
  assign rsp.slot_index   = out.slot_index;
  assign rsp.fired_action = out.fired_action;
  assign rsp.fired_tag    = out.fired_tag;
  assign rsp.last         = out.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      cnt        <= '0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (finish || (advance && expire && pend_valid)) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.valid && cmd.ready) begin
        busy       <= (ttst_pkg::op_e'(cmd.op) != ttst_pkg::OP_NONE);
        op_r       <= ttst_pkg::op_e'(cmd.op);
        dur_r      <= cmd.duration;
        act_r      <= cmd.action_code;
        tag_r      <= cmd.tag;
        hold_r     <= cmd.hold;
        cnt        <= '0;
        found      <= 1'b0;
        pend_valid <= 1'b0;
      end
      if (advance) begin
        cnt <= cnt + 1'b1;
        if (take) begin
          found     <= 1'b1;
          found_idx <= cur_idx;
        end
        if (expire) begin
          pend.kind         <= ttst_pkg::KIND_EXPIRED;
          pend.slot_index   <= cur_idx;
          pend.fired_action <= head.act;
          pend.fired_tag    <= head.tag;
          pend.last         <= 1'b0;
          pend_valid        <= 1'b1;
          if (pend_valid) begin
            out <= pend;
          end
        end
      end
      if (finish) begin
        busy <= 1'b0;
        out  <= final_res;
      end
    end
  end

endmodule

// ----- src/ttst_check.sv -----
module ttst_check (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic [1:0] cmd_op,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] rsp_kind,
  input logic [2:0] rsp_slot_index,
  input logic [7:0] rsp_fired_action,
  input logic [7:0] rsp_fired_tag,
  input logic       rsp_last
);

  // a result waiting on a stall stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // only expiries may be followed by more results for the same command
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_kind != ttst_pkg::KIND_EXPIRED) |-> rsp_last)
    else $error("non-expiry result without last");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_kind == ttst_pkg::KIND_FULL ||
                  rsp_kind == ttst_pkg::KIND_CANCELLED ||
                  rsp_kind == ttst_pkg::KIND_QUIET_TICK)
    |-> rsp_slot_index == '0 && rsp_fired_action == '0 && rsp_fired_tag == '0)
    else $error("nonzero fields on a plain result");

  // a real command keeps the command port closed while it runs
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_op != ttst_pkg::OP_NONE) |=> !cmd_ready)
    else $error("command taken while another is in progress");

endmodule

bind tagged_timer_slot_table_top ttst_check u_check (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .cmd_op           (cmd.op),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_kind         (rsp.kind),
  .rsp_slot_index   (rsp.slot_index),
  .rsp_fired_action (rsp.fired_action),
  .rsp_fired_tag    (rsp.fired_tag),
  .rsp_last         (rsp.last)
);

// ----- tb/sv/ttst_event_checker.sv -----
module ttst_event_checker
  import ttst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ttst_cmd_if  cmd,
  ttst_rsp_if  rsp,
  output int   mismatches,
  output int   outstanding,
  output int   checked,
  output int   expiries
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // shadow copy of the timer table
  slot_t   slots [SLOTS];
  result_t timer_events [$];
  int      bad_cnt    = 0;
  int      ok_cnt     = 0;
  int      expiry_cnt = 0;

  function automatic result_t make_event(kind_e k, int idx, logic [ACT_W-1:0] a,
                                         logic [TAG_W-1:0] t);
    result_t r;
    r.kind         = k;
    r.slot_index   = IDX_W'(idx);
    r.fired_action = a;
    r.fired_tag    = t;
    r.last         = 1'b0;
    return r;
  endfunction

  task automatic apply_timer_cmd(input op_e op, input logic [DUR_W-1:0] dur,
                                 input logic [ACT_W-1:0] act_code,
                                 input logic [TAG_W-1:0] tg, input logic hld);
    result_t batch [$];
    int      free_idx;
    int      i;
    free_idx = -1;
    case (op)
      OP_ADD: begin
        for (i = 0; i < SLOTS; i++)
          if (free_idx < 0 && slots[i].rem == '0) free_idx = i;
        if (free_idx < 0) begin
          batch.push_back(make_event(KIND_FULL, 0, '0, '0));
        end else begin
          slots[free_idx].rem = dur;
          slots[free_idx].act = act_code;
          slots[free_idx].tag = tg;
          batch.push_back(make_event(KIND_ADDED, free_idx, '0, '0));
        end
      end
      OP_TICK: begin
        if (!hld) begin
          for (i = 0; i < SLOTS; i++) begin
            if (slots[i].rem != '0) begin
              slots[i].rem = slots[i].rem - 1'b1;
              if (slots[i].rem == '0)
                batch.push_back(make_event(KIND_EXPIRED, i, slots[i].act, slots[i].tag));
            end
          end
        end
        if (batch.size() == 0) batch.push_back(make_event(KIND_QUIET_TICK, 0, '0, '0));
      end
      OP_CANCEL: begin
        // free slots carrying the tag are cleared too, which changes nothing
        for (i = 0; i < SLOTS; i++)
          if (slots[i].tag == tg) slots[i].rem = '0;
        batch.push_back(make_event(KIND_CANCELLED, 0, '0, '0));
      end
      default: ;
    endcase
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last = 1'b1;
      for (i = 0; i < batch.size(); i++) timer_events.push_back(batch[i]);
    end
  endtask

  task automatic check_event();
    result_t want;
    if (timer_events.size() == 0) begin
      bad_cnt++;
      if (bad_cnt <= REPORT_LIMIT)
        $display("[%0t] unexpected result: kind=%0d slot=%0d action=%02h tag=%02h last=%0b",
                 $time, rsp.kind, rsp.slot_index, rsp.fired_action, rsp.fired_tag, rsp.last);
    end else begin
      want = timer_events.pop_front();
      ok_cnt++;
      if (want.kind == KIND_EXPIRED) expiry_cnt++;
      if (rsp.kind !== want.kind || rsp.slot_index !== want.slot_index ||
          rsp.fired_action !== want.fired_action || rsp.fired_tag !== want.fired_tag ||
          rsp.last !== want.last) begin
        bad_cnt++;
        if (bad_cnt <= REPORT_LIMIT) begin
          $display("[%0t] result mismatch", $time);
          $display("  expected kind=%0d slot=%0d action=%02h tag=%02h last=%0b",
                   want.kind, want.slot_index, want.fired_action, want.fired_tag, want.last);
          $display("  actual   kind=%0d slot=%0d action=%02h tag=%02h last=%0b",
                   rsp.kind, rsp.slot_index, rsp.fired_action, rsp.fired_tag, rsp.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SLOTS; k++) slots[k] = '0;
      timer_events.delete();
    end else begin
      if (cmd.valid && cmd.ready)
        apply_timer_cmd(op_e'(cmd.op), cmd.duration, cmd.action_code, cmd.tag, cmd.hold);
      if (rsp.valid && rsp.ready) check_event();
    end
    mismatches  <= bad_cnt;
    outstanding <= timer_events.size();
    checked     <= ok_cnt;
    expiries    <= expiry_cnt;
  end

endmodule

// ----- tb/sv/tagged_timer_slot_table_top_tb.sv -----
module tagged_timer_slot_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttst_pkg::*;

  localparam int TOTAL_ITEMS     = 230;
  localparam int PRESSURE_AT     = 120;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES    = 24;
  localparam int WATCHDOG_LIMIT  = 3000;

  logic clk      = 1'b0;
  logic rst      = 1'b1;
  logic no_idle  = 1'b0;
  logic stall_req = 1'b0;
  int   items_sent = 0;
  int   directed_items = 0;
  int   quiet_cycles = 0;

  int mismatches;
  int outstanding;
  int checked;
  int expiries;

  ttst_cmd_if cmd ();
  ttst_rsp_if rsp ();

  tagged_timer_slot_table_top dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  ttst_event_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .expiries    (expiries)
  );

  always #6 clk = ~clk;

  task automatic send_cmd(input op_e op, input logic [DUR_W-1:0] dur,
                          input logic [ACT_W-1:0] act_code, input logic [TAG_W-1:0] tg,
                          input logic hld);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.op          <= op;
    cmd.duration    <= dur;
    cmd.action_code <= act_code;
    cmd.tag         <= tg;
    cmd.hold        <= hld;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic send_random_cmd();
    int               pick;
    int               dsel;
    op_e              op;
    logic [DUR_W-1:0] dur;
    logic [ACT_W-1:0] act_code;
    logic [TAG_W-1:0] tg;
    logic             hld;
    pick     = $urandom_range(0, 99);
    dsel     = $urandom_range(0, 99);
    act_code = ACT_W'($urandom);
    hld      = ($urandom_range(0, 99) < 15);
    // a small tag pool keeps cancels hitting live timers
    tg = ($urandom_range(0, 4) == 0) ? TAG_W'($urandom) : TAG_W'($urandom_range(0, 3));
    if (dsel < 5) begin
      dur = '0;
    end else if (dsel < 85) begin
      dur = DUR_W'($urandom_range(1, 6));
    end else begin
      // long timers only get pool tags so a cancel can free them
      dur = DUR_W'($urandom);
      tg  = TAG_W'($urandom_range(0, 3));
    end
    if (pick < 42)      op = OP_ADD;
    else if (pick < 84) op = OP_TICK;
    else if (pick < 97) op = OP_CANCEL;
    else                op = OP_NONE;
    send_cmd(op, dur, act_code, tg, hld);
  endtask

  initial begin
    int k;
    int random_idx;
    logic pressure_done;
    cmd.valid       <= 1'b0;
    cmd.op          <= OP_ADD;
    cmd.duration    <= '0;
    cmd.action_code <= '0;
    cmd.tag         <= '0;
    cmd.hold        <= 1'b0;
    pressure_done = 1'b0;
    random_idx    = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: held tick, plain tick, unused op, cancel of free slots
    send_cmd(OP_TICK, '0, '0, '0, 1'b1);
    send_cmd(OP_TICK, '0, '0, '0, 1'b0);
    send_cmd(OP_NONE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
    send_cmd(OP_CANCEL, '0, '0, 8'h00, 1'b0);
    // zero duration leaves slot 0 free, so the next add lands there again
    send_cmd(OP_ADD, 16'h0000, 8'hFF, 8'hAA, 1'b0);
    send_cmd(OP_ADD, 16'h0001, 8'h00, 8'h00, 1'b0);
    send_cmd(OP_ADD, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
    send_cmd(OP_ADD, 16'h0001, 8'h5A, 8'h11, 1'b0);
    for (k = 0; k < 4; k++)
      send_cmd(OP_ADD, 16'h0002, ACT_W'(8'hA0 + k), TAG_W'(8'h21 + k), 1'b0);
    send_cmd(OP_ADD, 16'h0003, 8'h77, 8'h33, 1'b0);
    send_cmd(OP_TICK, '0, '0, '0, 1'b1);
    send_cmd(OP_TICK, '0, '0, '0, 1'b0);
    send_cmd(OP_CANCEL, '0, '0, 8'hFF, 1'b0);
    send_cmd(OP_TICK, '0, '0, '0, 1'b0);
    // every slot expiring on one tick
    for (k = 0; k < SLOTS; k++)
      send_cmd(OP_ADD, 16'h0001, ACT_W'(8'h10 * k + 8'h0F), TAG_W'(8'hF0 - k), 1'b0);
    send_cmd(OP_TICK, '0, '0, '0, 1'b0);
    directed_items = items_sent;

    while (items_sent < TOTAL_ITEMS) begin
      if (!pressure_done && items_sent >= PRESSURE_AT) begin
        stall_req     = 1'b1;
        pressure_done = 1'b1;
      end
      no_idle = (random_idx >= 150 && random_idx < 180);
      send_random_cmd();
      random_idx++;
    end
    no_idle = 1'b0;
    cmd.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands (%0d directed), checked %0d results with %0d expiries.",
             items_sent, directed_items, checked, expiries);
    $display("Random gaps on both channels plus one %0d-cycle result back-pressure stretch.",
             HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off to back up the command side
  initial begin
    int w;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        rsp.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        w = no_idle ? 0 : $urandom_range(0, 3);
        if (w > 0) begin
          rsp.ready <= 1'b0;
          repeat (w) @(posedge clk);
        end
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, outstanding);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
